@@ rtl/rrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_pkg
// Types, codes and constants shared by the RAID10 request mapper.
// ----------------------------------------------------------------------------
package rrm_pkg;

	localparam int MAX_DEVICES     = 16;
	localparam int DEV_BITS        = $clog2(MAX_DEVICES);
	localparam int BLK_BITS        = 2;
	localparam int BLOCK_SECTORS   = 1 << BLK_BITS;
	localparam int DEV_SECTOR_BITS = 19;
	localparam int START_BITS      = 23;
	localparam int ROW_BITS        = START_BITS - BLK_BITS;
	localparam int POS_BITS        = START_BITS + 1;
	localparam int COUNT_LIMIT     = 32;
	localparam int GROUP_MAX       = 16;
	localparam int MIRROR_MAX      = 4;
	localparam int GRP_BITS        = 4;
	localparam int IDX_BITS        = 6;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_KILL   = 2'd2,
		OP_REPAIR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_MIRROR = 2'd1,
		ST_BEYOND    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_GROUP_COUNT  = 1'b0,
		REG_MIRROR_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_DIV,
		SEQ_SCAN,
		SEQ_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [START_BITS-1:0] start_sector;
		logic [5:0]            sector_count;
		logic [DEV_BITS-1:0]   device_number;
	} rrm_req_t;

	typedef struct packed {
		logic [DEV_BITS-1:0]        chosen_device;
		logic [MAX_DEVICES-1:0]     written_mask;
		logic [DEV_SECTOR_BITS-1:0] device_first_sector;
		logic [DEV_SECTOR_BITS-1:0] device_last_sector;
		logic [1:0]                 status;
		logic                       last;
	} rrm_rsp_t;

	typedef struct packed {
		logic                  done;
		logic [ROW_BITS-1:0]   quot;
		logic [GRP_BITS-1:0]   rem;
	} div_res_t;

	typedef struct packed {
		logic                   done;
		logic                   found;
		logic [DEV_BITS-1:0]    chosen;
		logic [MAX_DEVICES-1:0] mask;
	} scan_res_t;

endpackage
`default_nettype wire

@@ rtl/rrm_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_divider
// Restoring divider, one quotient bit per cycle: block number by group count.
// ----------------------------------------------------------------------------
module rrm_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rrm_pkg::ROW_BITS-1:0] dividend,
	input  wire logic [4:0]                 divisor,
	output rrm_pkg::div_res_t               res
);
	import rrm_pkg::*;

	localparam int CNT_BITS = $clog2(ROW_BITS);

	logic                active_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [4:0]          rem_q;
	logic [4:0]          div_q;
	logic [ROW_BITS-1:0] quo_q;
	logic [5:0]          trial;
	logic                fits;

	assign trial = {rem_q, quo_q[ROW_BITS-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_BITS'(ROW_BITS - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (active_q) begin
			rem_q <= fits ? 5'(trial - {1'b0, div_q}) : trial[4:0];
			quo_q <= {quo_q[ROW_BITS-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q[GRP_BITS-1:0];

endmodule
`default_nettype wire

@@ rtl/rrm_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_scan
// Walks the mirrors of one group, one device per cycle, collecting the
// lowest alive device and the mask of all alive ones.
// ----------------------------------------------------------------------------
module rrm_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [rrm_pkg::IDX_BITS-1:0]  base,
	input  wire logic [2:0]                    mirrors,
	input  wire logic [rrm_pkg::MAX_DEVICES-1:0] alive,
	output rrm_pkg::scan_res_t                 res
);
	import rrm_pkg::*;

	logic                   active_q;
	logic                   done_q;
	logic [1:0]             j_q;
	logic [1:0]             jlast_q;
	logic [IDX_BITS-1:0]    base_q;
	logic                   found_q;
	logic [DEV_BITS-1:0]    chosen_q;
	logic [MAX_DEVICES-1:0] mask_q;
	logic [IDX_BITS-1:0]    idx;
	logic                   hit;

	assign idx = base_q + IDX_BITS'(j_q);
	assign hit = (idx[IDX_BITS-1:DEV_BITS] == '0) && alive[idx[DEV_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			j_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				j_q      <= '0;
			end else if (active_q) begin
				if (j_q == jlast_q) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			base_q  <= base;
			jlast_q <= 2'(mirrors - 3'd1);
			found_q <= 1'b0;
			mask_q  <= '0;
		end else if (active_q && hit) begin
			if (!found_q)
				chosen_q <= idx[DEV_BITS-1:0];
			found_q                     <= 1'b1;
			mask_q[idx[DEV_BITS-1:0]]   <= 1'b1;
		end
	end

	assign res.done   = done_q;
	assign res.found  = found_q;
	assign res.chosen = chosen_q;
	assign res.mask   = mask_q;

endmodule
`default_nettype wire

@@ rtl/rrm_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrm_seq
// Request sequencer: divides the first block once, then steps chunk by
// chunk, scanning mirrors and loading the result register.
// ----------------------------------------------------------------------------
module rrm_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire rrm_pkg::rrm_req_t               in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output rrm_pkg::rrm_rsp_t                    out_data,
	input  wire logic [4:0]                      group_count,
	input  wire logic [2:0]                      mirror_count,
	input  wire logic [rrm_pkg::MAX_DEVICES-1:0] alive
);
	import rrm_pkg::*;

	seq_state_t           state_q, state_d;
	logic [POS_BITS-1:0]  i_q, end_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [GRP_BITS-1:0]  grp_q;
	logic [4:0]           g_q;
	logic [2:0]           m_q;
	logic                 wr_q;
	logic                 out_valid_q;
	rrm_rsp_t             out_q;

	logic [4:0]           g_eff;
	logic [2:0]           m_eff;
	logic [5:0]           cnt_eff;
	logic                 is_rw;
	logic                 take;

	div_res_t             div_res;
	scan_res_t            scan_res;
	logic                 div_start, scan_start, out_load, out_free;

	logic [1:0]           off;
	logic [2:0]           room;
	logic [POS_BITS-1:0]  left;
	logic [2:0]           n_eff;
	logic                 fin;
	logic [START_BITS-1:0] first;
	logic [POS_BITS-1:0]  lastsec;
	logic                 cap_err;
	logic                 err;
	logic                 ending;
	logic [4:0]           grp_inc;
	logic                 wrap;
	logic [GRP_BITS-1:0]  grp_sel;
	logic [6:0]           prod;
	rrm_rsp_t             rsp;

	always_comb begin
		priority if (group_count == 5'd0)
			g_eff = 5'd1;
		else if (group_count > 5'(GROUP_MAX))
			g_eff = 5'(GROUP_MAX);
		else
			g_eff = group_count;
		priority if (mirror_count == 3'd0)
			m_eff = 3'd1;
		else if (mirror_count > 3'(MIRROR_MAX))
			m_eff = 3'(MIRROR_MAX);
		else
			m_eff = mirror_count;
		cnt_eff = (in_data.sector_count > 6'(COUNT_LIMIT)) ? 6'(COUNT_LIMIT)
			: in_data.sector_count;
	end

	assign is_rw = (op_t'(in_data.op) == OP_READ) || (op_t'(in_data.op) == OP_WRITE);
	assign take  = in_valid && is_rw && (cnt_eff != '0);

	// chunk arithmetic
	assign off     = i_q[BLK_BITS-1:0];
	assign room    = 3'(BLOCK_SECTORS) - {1'b0, off};
	assign left    = end_q - i_q;
	assign fin     = left <= POS_BITS'(room);
	assign n_eff   = fin ? left[2:0] : room;
	assign first   = {row_q, off};
	assign lastsec = {1'b0, first} + POS_BITS'(n_eff) - POS_BITS'(1);
	assign cap_err = lastsec[POS_BITS-1:DEV_SECTOR_BITS] != '0;
	assign err     = !scan_res.found || cap_err;
	assign ending  = err || fin;

	assign grp_inc = {1'b0, grp_q} + 5'd1;
	assign wrap    = grp_inc == g_q;

	always_comb begin
		rsp = '0;
		priority if (!scan_res.found) begin
			rsp.status = ST_NO_MIRROR;
			rsp.last   = 1'b1;
		end else if (cap_err) begin
			rsp.status = ST_BEYOND;
			rsp.last   = 1'b1;
		end else begin
			rsp.chosen_device       = scan_res.chosen;
			rsp.written_mask        = wr_q ? scan_res.mask : '0;
			rsp.device_first_sector = first[DEV_SECTOR_BITS-1:0];
			rsp.device_last_sector  = lastsec[DEV_SECTOR_BITS-1:0];
			rsp.status              = ST_OK;
			rsp.last                = fin;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: if (take) state_d = SEQ_DIV;
			SEQ_DIV:  if (div_res.done) state_d = SEQ_SCAN;
			SEQ_SCAN: if (scan_res.done) state_d = SEQ_EMIT;
			SEQ_EMIT: if (out_free) state_d = ending ? SEQ_IDLE : SEQ_SCAN;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall   = 1'b1;
		div_start  = 1'b0;
		scan_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				in_stall  = 1'b0;
				div_start = take;
			end
			SEQ_DIV:  scan_start = div_res.done;
			SEQ_SCAN: ;
			SEQ_EMIT: begin
				out_load   = out_free;
				scan_start = out_free && !ending;
			end
			default: ;
		endcase
	end

	assign grp_sel = (state_q == SEQ_DIV) ? div_res.rem : (wrap ? '0 : grp_inc[GRP_BITS-1:0]);
	assign prod    = 7'(grp_sel) * 7'(m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			i_q   <= {1'b0, in_data.start_sector};
			end_q <= {1'b0, in_data.start_sector} + POS_BITS'(cnt_eff);
			g_q   <= g_eff;
			m_q   <= m_eff;
			wr_q  <= op_t'(in_data.op) == OP_WRITE;
		end
		if (state_q == SEQ_DIV && div_res.done) begin
			row_q <= div_res.quot;
			grp_q <= div_res.rem;
		end
		if (scan_start && state_q == SEQ_EMIT) begin
			i_q   <= i_q + POS_BITS'(n_eff);
			grp_q <= grp_sel;
			if (wrap)
				row_q <= row_q + 1'b1;
		end
		if (out_load)
			out_q <= rsp;
	end

	rrm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.start_sector[START_BITS-1:BLK_BITS]),
		.divisor  (g_eff),
		.res      (div_res)
	);

	rrm_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.base    (prod[IDX_BITS-1:0]),
		.mirrors (m_q),
		.alive   (alive),
		.res     (scan_res)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ rtl/raid10_request_mapper.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raid10_request_mapper
// Maps read/write requests onto a RAID10 array, one beat per chunk; keeps
// the device alive mask and the group/mirror count registers.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   in       | in_valid/in_stall  | in_data   (rrm_req_t)
//   out      | out_valid/out_stall| out_data  (rrm_rsp_t)
//   config   | APB psel/penable   | paddr, pwdata, prdata
//
// A request of k chunks goes through the bit-serial divider once, then for
// each chunk a scan of m mirrors and one load, m the mirror count. Kill,
// repair and zero-length requests are accepted from idle and start no division.
// Reset leaves every device alive, groups 2, mirrors 2, no beat pending.
// A stalled output beat holds the sequencer in its load state.
// ----------------------------------------------------------------------------
module raid10_request_mapper (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rrm_pkg::rrm_req_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rrm_pkg::rrm_rsp_t      out_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import rrm_pkg::*;

	logic [4:0]             group_count_q;
	logic [2:0]             mirror_count_q;
	logic [MAX_DEVICES-1:0] alive_q;
	logic                   cfg_wr;
	logic                   dev_evt;
	reg_idx_t               reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign dev_evt = in_valid && !in_stall
		&& ((op_t'(in_data.op) == OP_KILL) || (op_t'(in_data.op) == OP_REPAIR));

	always_comb begin
		unique case (reg_idx)
			REG_GROUP_COUNT:  prdata = 32'(group_count_q);
			REG_MIRROR_COUNT: prdata = 32'(mirror_count_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= 5'd2;
			mirror_count_q <= 3'd2;
			alive_q        <= '1;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx)
					REG_GROUP_COUNT:  group_count_q  <= pwdata[4:0];
					REG_MIRROR_COUNT: mirror_count_q <= pwdata[2:0];
					default: ;
				endcase
			end
			if (dev_evt)
				alive_q[in_data.device_number] <= op_t'(in_data.op) == OP_REPAIR;
		end
	end

	rrm_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.group_count  (group_count_q),
		.mirror_count (mirror_count_q),
		.alive        (alive_q)
	);

endmodule
`default_nettype wire
